// ===== hdl/scso_pkg.sv =====
// Shared types, constants and bit-map helpers for the stepper command shift-out block.
// No dependencies; imported by scso_ctrl and the top level.
`default_nettype none

package scso_pkg;

    // Default build values.
    localparam int CHAIN_BITS_DEF   = 24;
    localparam int PERIOD_SCALE_DEF = 10;

    // Fixed field widths.
    localparam int ACTION_W = 3;
    localparam int MODE_W   = 3;
    localparam int IDX_W    = 5;
    localparam int MOTOR_W  = 2;
    localparam int INC_W    = 10;
    localparam int PERIOD_W = 16;
    localparam int WAIT_W   = 20;
    localparam int CFG_A_W  = 1;
    localparam int CFG_D_W  = 10;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 8;

    // Reset values.
    localparam logic [31:0]         IMG_RESET    = 32'h00FF_8FFF;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd5000;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 16'hFFFF;
    localparam logic [MOTOR_W-1:0]  MOTOR_RESET  = 2'd1;
    localparam logic [INC_W-1:0]    INC_RESET    = 10'd30;

    // Microstep mode lines.
    localparam logic [31:0] BIT_M2    = 32'h0000_0020;
    localparam logic [31:0] BIT_M1    = 32'h0000_0040;
    localparam logic [31:0] BIT_M0    = 32'h0000_0080;
    localparam logic [31:0] MODE_MASK = BIT_M0 | BIT_M1 | BIT_M2;
    localparam logic [MODE_W-1:0] MODE_LAST = 3'd5;

    // Config register indexes.
    localparam logic [CFG_A_W-1:0] CFG_MOTOR_SELECT    = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_SPEED_INCREMENT = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK          = 3'd0,
        ACT_RUN_LEFT      = 3'd1,
        ACT_RUN_RIGHT     = 3'd2,
        ACT_STOP          = 3'd3,
        ACT_FASTER        = 3'd4,
        ACT_SLOWER        = 3'd5,
        ACT_SET_MICROSTEP = 3'd6
    } t_action;

    function automatic logic [31:0] dir_mask(input logic [MOTOR_W-1:0] m);
        logic [31:0] r;
        unique case (m)
            2'd1:    r = 32'h0000_0010;
            2'd2:    r = 32'h0000_0004;
            2'd3:    r = 32'h0000_0001;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] step_mask(input logic [MOTOR_W-1:0] m);
        logic [31:0] r;
        unique case (m)
            2'd1:    r = 32'h0000_0008;
            2'd2:    r = 32'h0000_0002;
            2'd3:    r = 32'h0000_8000;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] mode_bits(input logic [MODE_W-1:0] md);
        logic [31:0] r;
        unique case (md)
            3'd0:    r = 32'h0;
            3'd1:    r = BIT_M0;
            3'd2:    r = BIT_M1;
            3'd3:    r = BIT_M0 | BIT_M1;
            3'd4:    r = BIT_M2;
            3'd5:    r = BIT_M0 | BIT_M2;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/scso_cell.sv =====
// One cell of the output shift chain: holds one image bit.
// Depends on nothing; instantiated in a row by the top level.
`default_nettype none

module scso_cell (
    input  wire  i_clk,
    input  wire  i_load,
    input  wire  i_shift,
    input  wire  i_load_bit,
    input  wire  i_next_bit,
    output logic o_bit
);

    logic r_bit;

    // parallel load wins; otherwise take the upstream neighbor's bit
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bit <= i_load_bit;
        end else if (i_shift) begin
            r_bit <= i_next_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

`default_nettype wire

// ===== hdl/scso_ctrl.sv =====
// Command decode and state: output image, step period, run flag, wait counter, config.
// Depends on scso_pkg.
`default_nettype none

module scso_ctrl #(
    parameter int CHAIN_BITS   = scso_pkg::CHAIN_BITS_DEF,
    parameter int PERIOD_SCALE = scso_pkg::PERIOD_SCALE_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_fire,
    input  wire  [scso_pkg::ACTION_W-1:0]  i_action,
    input  wire  [scso_pkg::MODE_W-1:0]    i_mode,
    input  wire                            i_cfg_we,
    input  wire  [scso_pkg::CFG_A_W-1:0]   i_cfg_addr,
    input  wire  [scso_pkg::CFG_D_W-1:0]   i_cfg_wdata,
    output logic                           o_emit,
    output logic [CHAIN_BITS-1:0]          o_image
);

    import scso_pkg::*;

    localparam int PROD_W = PERIOD_W + 5;

    logic [CHAIN_BITS-1:0] r_image, n_image;
    logic [PERIOD_W-1:0]   r_period, n_period;
    logic                  r_running, n_running;
    logic [WAIT_W-1:0]     r_wait, n_wait;
    logic [MOTOR_W-1:0]    r_motor;
    logic [INC_W-1:0]      r_inc;

    logic [31:0]           w_img;
    logic [PROD_W-1:0]     w_prod;
    logic [PERIOD_W:0]     w_sum;
    logic                  w_emit;

    assign w_prod = PROD_W'(r_period) * PROD_W'(PERIOD_SCALE);
    assign w_sum  = {1'b0, r_period} + (PERIOD_W+1)'(r_inc);

    always_comb begin
        w_img                 = '0;
        w_img[CHAIN_BITS-1:0] = r_image;
        n_period              = r_period;
        n_running             = r_running;
        n_wait                = r_wait;
        w_emit                = 1'b0;
        unique case (t_action'(i_action))
            ACT_TICK: begin
                if (r_wait != '0) begin
                    n_wait = r_wait - 1'b1;
                end else if (r_running) begin
                    n_wait = WAIT_W'(w_prod - 1'b1);
                    if (r_motor != '0) begin
                        w_img  = w_img ^ step_mask(r_motor);
                        w_emit = 1'b1;
                    end
                end
            end
            ACT_RUN_LEFT, ACT_RUN_RIGHT: begin
                n_running = 1'b1;
                if (r_motor != '0) begin
                    if (t_action'(i_action) == ACT_RUN_LEFT) begin
                        w_img = w_img | dir_mask(r_motor);
                    end else begin
                        w_img = w_img & ~dir_mask(r_motor);
                    end
                    w_emit = 1'b1;
                end
            end
            ACT_STOP: begin
                n_running = 1'b0;
            end
            ACT_FASTER: begin
                if (r_period > PERIOD_W'(r_inc)) begin
                    n_period = r_period - PERIOD_W'(r_inc);
                end else begin
                    n_period = PERIOD_W'(1);
                end
            end
            ACT_SLOWER: begin
                n_period = w_sum[PERIOD_W] ? PERIOD_MAX : w_sum[PERIOD_W-1:0];
            end
            ACT_SET_MICROSTEP: begin
                if (i_mode <= MODE_LAST) begin
                    w_img  = (w_img & ~MODE_MASK) | mode_bits(i_mode);
                    w_emit = 1'b1;
                end
            end
            default: ;   // unused action code
        endcase
        n_image = w_img[CHAIN_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image   <= IMG_RESET[CHAIN_BITS-1:0];
            r_period  <= PERIOD_RESET;
            r_running <= 1'b1;
            r_wait    <= '0;
            r_motor   <= MOTOR_RESET;
            r_inc     <= INC_RESET;
        end else begin
            if (i_fire) begin
                r_image   <= n_image;
                r_period  <= n_period;
                r_running <= n_running;
                r_wait    <= n_wait;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_MOTOR_SELECT:    r_motor <= i_cfg_wdata[MOTOR_W-1:0];
                    CFG_SPEED_INCREMENT: r_inc   <= i_cfg_wdata[INC_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_emit  = w_emit;
    assign o_image = n_image;

endmodule

`default_nettype wire

// ===== hdl/stepper_command_shift_out.sv =====
// Top level of the stepper command block: command stream in, serial image bits out.
// Depends on scso_pkg, scso_ctrl and scso_cell.
`default_nettype none

//  channel   direction  handshake            payload
//  s (cmd)   in         i_s_tvalid/o_s_tready  action, microstep_mode
//  m (bits)  out        o_m_tvalid/i_m_tready  serial_bit, bit_index; tlast = latch
//  cfg       in         i_cfg_we               motor_select (0), speed_increment (1)
//
//  A command that changes the image loads all CHAIN_BITS cells at once and
//  the chain then drains one bit per output request.
//  Commands that emit nothing are taken every cycle while the chain is empty; the
//  next command is also taken in the cycle the last bit leaves.
//  Reset is synchronous; a stalled output simply holds the chain in place.
module stepper_command_shift_out #(
    parameter int CHAIN_BITS   = scso_pkg::CHAIN_BITS_DEF,
    parameter int PERIOD_SCALE = scso_pkg::PERIOD_SCALE_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // [2:0] action, [5:3] microstep_mode, [7:6] zero
    input  wire  [scso_pkg::S_DATA_W-1:0]  i_s_tdata,
    input  wire                            i_s_tvalid,
    output logic                           o_s_tready,
    // [0] serial_bit, [5:1] bit_index, [7:6] zero
    output logic [scso_pkg::M_DATA_W-1:0]  o_m_tdata,
    output logic                           o_m_tvalid,
    output logic                           o_m_tlast,
    input  wire                            i_m_tready,
    input  wire                            i_cfg_we,
    input  wire  [scso_pkg::CFG_A_W-1:0]   i_cfg_addr,
    input  wire  [scso_pkg::CFG_D_W-1:0]   i_cfg_wdata
);

    import scso_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHAIN_BITS - 1);

    logic                  r_busy;
    logic [IDX_W-1:0]      r_idx;
    logic                  w_in_fire, w_out_fire, w_last, w_load, w_shift, w_emit;
    logic [CHAIN_BITS-1:0] w_image;
    logic [CHAIN_BITS-1:0] w_cell;

    assign w_last     = (r_idx == LAST_IDX);
    assign w_out_fire = r_busy & i_m_tready;
    assign o_s_tready = ~r_busy | (w_last & i_m_tready);
    assign w_in_fire  = i_s_tvalid & o_s_tready;
    assign w_load     = w_in_fire & w_emit;
    assign w_shift    = w_out_fire;

    scso_ctrl #(
        .CHAIN_BITS   (CHAIN_BITS),
        .PERIOD_SCALE (PERIOD_SCALE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_in_fire),
        .i_action    (i_s_tdata[ACTION_W-1:0]),
        .i_mode      (i_s_tdata[ACTION_W +: MODE_W]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_emit      (w_emit),
        .o_image     (w_image)
    );

    // shift chain: cell 0 drives the output, each cell but the top takes from the one above
    for (genvar g = 0; g < CHAIN_BITS; g++) begin : g_cell
        logic w_next;
        if (g == CHAIN_BITS - 1) begin : g_top
            assign w_next = 1'b0;
        end else begin : g_mid
            assign w_next = w_cell[g+1];
        end
        scso_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (w_load),
            .i_shift    (w_shift),
            .i_load_bit (w_image[g]),
            .i_next_bit (w_next),
            .o_bit      (w_cell[g])
        );
    end

    // bit position counter and chain-occupied flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (w_out_fire) begin
                r_idx <= r_idx + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_m_tvalid = r_busy;
    assign o_m_tlast  = w_last;
    assign o_m_tdata  = {2'b00, r_idx, w_cell[0]};

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking bench for stepper_command_shift_out: command requests in, serial image bits out.
// Depends on scso_pkg and the stepper_command_shift_out RTL; the bit-level prediction is its own.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scso_pkg::*;

    localparam int CHAIN_LEN     = CHAIN_BITS_DEF;
    localparam int TICK_SCALE    = PERIOD_SCALE_DEF;
    // The settle pause covers an image's drain plus the command pipe.
    localparam int SETTLE_CYCLES = CHAIN_LEN + 8;
    // Longest legal quiet stretch is the longest gap or stall plus a settle pause.
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 55;

    // Action code that the block does not decode.
    localparam logic [ACTION_W-1:0] ACT_RESERVED = 3'd7;

    // Image bit positions of the three drivers and the mode lines.
    localparam int IMG_M1_DIR  = 4;
    localparam int IMG_M1_STEP = 3;
    localparam int IMG_M2_DIR  = 2;
    localparam int IMG_M2_STEP = 1;
    localparam int IMG_M3_DIR  = 0;
    localparam int IMG_M3_STEP = 15;
    localparam int IMG_MODE_M0 = 7;
    localparam int IMG_MODE_M1 = 6;
    localparam int IMG_MODE_M2 = 5;

    typedef enum logic [MODE_W-1:0] {
        MS_FULL         = 3'd0,
        MS_HALF         = 3'd1,
        MS_QUARTER      = 3'd2,
        MS_EIGHTH       = 3'd3,
        MS_SIXTEENTH    = 3'd4,
        MS_THIRTYSECOND = 3'd5,
        MS_RSVD6        = 3'd6,
        MS_RSVD7        = 3'd7
    } t_microstep;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        t_microstep          ms;
    } t_cmd;

    typedef struct packed {
        logic             sbit;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_chain_bit;

    // ---------------------------------------------------------------- clock, DUT
    logic                 i_clk     = 1'b0;
    logic                 rst_n     = 1'b0;
    logic [S_DATA_W-1:0]  s_data    = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [M_DATA_W-1:0]  m_data;
    logic                 m_valid;
    logic                 m_last;
    logic                 m_ready   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_A_W-1:0]   cfg_addr  = '0;
    logic [CFG_D_W-1:0]   cfg_wdata = '0;

    always #5 i_clk = ~i_clk;

    stepper_command_shift_out u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_s_tdata   (s_data),     // [2:0] action, [5:3] microstep_mode, [7:6] zero
        .i_s_tvalid  (s_valid),
        .o_s_tready  (s_ready),
        .o_m_tdata   (m_data),     // [0] serial_bit, [5:1] bit_index, [7:6] zero
        .o_m_tvalid  (m_valid),
        .o_m_tlast   (m_last),
        .i_m_tready  (m_ready),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    // ---------------------------------------------------------------- shared state
    t_cmd       cmd_pending[$];    // requests not yet presented to the block
    t_chain_bit chain_due[$];      // image bits predicted but not yet seen
    int         cmds_queued   = 0;
    int         cmds_accepted = 0;
    int         errors        = 0;
    int         idle_cycles   = 0;
    logic       s_fire        = 1'b0;   // request taken at the last rising edge
    logic       quiet         = 1'b0;   // no new idling starts on either side while set

    // Predictor copy of the block's registers and state.
    logic [MOTOR_W-1:0]    motor     = MOTOR_RESET;
    logic [INC_W-1:0]      incr      = INC_RESET;
    logic [CHAIN_LEN-1:0]  image     = IMG_RESET[CHAIN_LEN-1:0];
    logic [PERIOD_W-1:0]   period    = PERIOD_RESET;
    logic                  run_flag  = 1'b1;
    logic [WAIT_W-1:0]     wait_left = '0;

    // ---------------------------------------------------------------- predictor
    function automatic int dir_pos(input logic [MOTOR_W-1:0] m);
        case (m)
            2'd1:    return IMG_M1_DIR;
            2'd2:    return IMG_M2_DIR;
            default: return IMG_M3_DIR;
        endcase
    endfunction

    function automatic int step_pos(input logic [MOTOR_W-1:0] m);
        case (m)
            2'd1:    return IMG_M1_STEP;
            2'd2:    return IMG_M2_STEP;
            default: return IMG_M3_STEP;
        endcase
    endfunction

    // Every image update drains LSB first; the top bit carries the latch.
    task automatic queue_image();
        t_chain_bit cb;
        for (int b = 0; b < CHAIN_LEN; b++) begin
            cb.sbit = image[b];
            cb.idx  = b[IDX_W-1:0];
            cb.last = (b == CHAIN_LEN - 1);
            chain_due.push_back(cb);
        end
    endtask

    task automatic apply_command(input logic [ACTION_W-1:0] act, input t_microstep ms);
        int                reload;
        logic [PERIOD_W:0] sum;
        logic [2:0]        lines;   // {M0, M1, M2}
        case (act)
            ACT_TICK: begin
                if (wait_left != '0) begin
                    wait_left = wait_left - 1'b1;
                end else if (run_flag) begin
                    // a due tick reloads even when no motor is selected
                    reload    = TICK_SCALE * int'(period) - 1;
                    wait_left = reload[WAIT_W-1:0];
                    if (motor != '0) begin
                        image[step_pos(motor)] = ~image[step_pos(motor)];
                        queue_image();
                    end
                end
            end
            ACT_RUN_LEFT, ACT_RUN_RIGHT: begin
                run_flag = 1'b1;
                if (motor != '0) begin
                    image[dir_pos(motor)] = (act == ACT_RUN_LEFT);
                    queue_image();
                end
            end
            ACT_STOP: begin
                run_flag = 1'b0;
            end
            ACT_FASTER: begin
                // floor of one; a zero increment leaves the period alone
                if (period > incr) period = period - incr;
                else               period = 16'd1;
            end
            ACT_SLOWER: begin
                sum = {1'b0, period} + incr;
                if (sum > {1'b0, PERIOD_MAX}) period = PERIOD_MAX;
                else                          period = sum[PERIOD_W-1:0];
            end
            ACT_SET_MICROSTEP: begin
                if (ms <= MS_THIRTYSECOND) begin
                    case (ms)
                        MS_FULL:      lines = 3'b000;
                        MS_HALF:      lines = 3'b100;
                        MS_QUARTER:   lines = 3'b010;
                        MS_EIGHTH:    lines = 3'b110;
                        MS_SIXTEENTH: lines = 3'b001;
                        default:      lines = 3'b101;
                    endcase
                    image[IMG_MODE_M0] = lines[2];
                    image[IMG_MODE_M1] = lines[1];
                    image[IMG_MODE_M2] = lines[0];
                    queue_image();
                end
            end
            default: ;   // reserved action: no effect
        endcase
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t ns mismatch: %s got %0d want %0d", $time, what, got, want);
        errors++;
    endtask

    // ---------------------------------------------------------------- monitor
    // Everything is sampled at the rising edge; the bench drives on the falling one.
    always @(posedge i_clk) begin
        t_chain_bit want;
        logic       busy;
        busy = 1'b0;
        if (rst_n) begin
            // output side first, so a new image never masks a stray bit
            if (m_valid && m_ready) begin
                busy = 1'b1;
                if (chain_due.size() == 0) begin
                    flag_mismatch("bit with nothing expected, tdata", int'(m_data), 0);
                end else begin
                    want = chain_due.pop_front();
                    if (m_data[0] !== want.sbit)
                        flag_mismatch($sformatf("serial_bit at %0d", want.idx),
                                      int'(m_data[0]), int'(want.sbit));
                    if (m_data[5:1] !== want.idx)
                        flag_mismatch("bit_index", int'(m_data[5:1]), int'(want.idx));
                    if (m_last !== want.last)
                        flag_mismatch($sformatf("latch at %0d", want.idx),
                                      int'(m_last), int'(want.last));
                end
            end
            if (cfg_we) begin
                busy = 1'b1;
                if (cfg_addr == CFG_MOTOR_SELECT) motor = cfg_wdata[MOTOR_W-1:0];
                else                              incr  = cfg_wdata[INC_W-1:0];
            end
            if (s_valid && s_ready) begin
                busy = 1'b1;
                apply_command(s_data[ACTION_W-1:0], t_microstep'(s_data[ACTION_W +: MODE_W]));
                cmds_accepted++;
            end
            s_fire <= s_valid && s_ready;
            // watchdog: a run with no traffic at all for this long is hung
            if (busy) begin
                idle_cycles = 0;
            end else if (++idle_cycles >= STALL_LIMIT) begin
                $display("FAIL stepper_command_shift_out");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- idling
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Flip between idling and full-rate stretches now and then.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) quiet <= ~quiet;
    end

    // ---------------------------------------------------------------- command driver
    int gap_left = 0;

    always @(negedge i_clk) begin
        t_cmd req;
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (gap_left != 0) begin
                s_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (cmd_pending.size() != 0) begin
                req      = cmd_pending.pop_front();
                s_data   <= {2'b00, req.ms, req.act};
                s_valid  <= 1'b1;
                gap_left <= (quiet || $urandom_range(0, 9) < 6) ? 0 : idle_len();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- output stalls
    int stall_left = 0;

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= idle_len() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- stimulus
    task automatic push_cmd(input logic [ACTION_W-1:0] act, input t_microstep ms);
        t_cmd c;
        c.act = act;
        c.ms  = ms;
        cmd_pending.push_back(c);
        cmds_queued++;
    endtask

    // Mostly ticks and motion commands with random payload; fasters outnumber
    // slowers so the period stays short and steps keep coming. Reserved codes
    // are mixed in as noise and do not count toward the phase size.
    task automatic push_random_cmd(inout int counted);
        int         r;
        int         burst;
        t_microstep ms;
        r  = $urandom_range(0, 99);
        ms = t_microstep'($urandom_range(0, 7));
        if (r < 40) begin
            push_cmd(ACT_TICK, ms);
            counted++;
        end else if (r < 48) begin
            burst = $urandom_range(10, 25);
            repeat (burst) push_cmd(ACT_TICK, t_microstep'($urandom_range(0, 7)));
            counted += burst;
        end else if (r < 56) begin
            push_cmd(ACT_RUN_LEFT, ms);
            counted++;
        end else if (r < 64) begin
            push_cmd(ACT_RUN_RIGHT, ms);
            counted++;
        end else if (r < 68) begin
            push_cmd(ACT_STOP, ms);
            counted++;
        end else if (r < 80) begin
            push_cmd(ACT_FASTER, ms);
            counted++;
        end else if (r < 85) begin
            push_cmd(ACT_SLOWER, ms);
            counted++;
        end else if (r < 96) begin
            push_cmd(ACT_SET_MICROSTEP, ms);
            if (ms <= MS_THIRTYSECOND) counted++;
        end else begin
            push_cmd(ACT_RESERVED, ms);
        end
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Registers only change once every request is in and every bit is out.
    task automatic wait_idle();
        @(negedge i_clk);
        while (cmds_accepted != cmds_queued || chain_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Motor select only looks at its low bits; the rest of the word is noise.
    function automatic logic [CFG_D_W-1:0] motor_word(input logic [MOTOR_W-1:0] m);
        logic [31:0] noise;
        noise = $urandom();
        return {noise[CFG_D_W-1:MOTOR_W], m};
    endfunction

    initial begin
        int counted;
        repeat (10) @(negedge i_clk);
        rst_n <= 1'b1;

        // Reset values: every mode pattern, reserved modes and action, both
        // directions on motor 1, a stopped tick with nothing pending, and one
        // step of each speed command.
        @(posedge i_clk);
        push_cmd(ACT_SET_MICROSTEP, MS_FULL);
        push_cmd(ACT_SET_MICROSTEP, MS_HALF);
        push_cmd(ACT_SET_MICROSTEP, MS_QUARTER);
        push_cmd(ACT_SET_MICROSTEP, MS_EIGHTH);
        push_cmd(ACT_SET_MICROSTEP, MS_SIXTEENTH);
        push_cmd(ACT_SET_MICROSTEP, MS_THIRTYSECOND);
        push_cmd(ACT_SET_MICROSTEP, MS_RSVD6);
        push_cmd(ACT_SET_MICROSTEP, MS_RSVD7);
        push_cmd(ACT_RESERVED, MS_RSVD7);
        push_cmd(ACT_RUN_LEFT, MS_FULL);
        push_cmd(ACT_RUN_RIGHT, MS_RSVD7);
        push_cmd(ACT_STOP, MS_FULL);
        push_cmd(ACT_TICK, MS_FULL);
        push_cmd(ACT_FASTER, MS_FULL);
        push_cmd(ACT_SLOWER, MS_FULL);
        wait_idle();

        // Largest increment drives the period to its floor of one; motor 3
        // then steps on the first due tick and reloads the shortest wait.
        write_reg(CFG_SPEED_INCREMENT, 10'd1023);
        write_reg(CFG_MOTOR_SELECT, motor_word(2'd3));
        @(posedge i_clk);
        repeat (5) push_cmd(ACT_FASTER, MS_FULL);
        push_cmd(ACT_RUN_LEFT, MS_HALF);
        push_cmd(ACT_TICK, MS_FULL);
        push_cmd(ACT_TICK, MS_FULL);
        wait_idle();

        // Period ceiling: stopped, climb past 65535, then come back down to one.
        write_reg(CFG_SPEED_INCREMENT, 10'd1000);
        @(posedge i_clk);
        push_cmd(ACT_STOP, MS_FULL);
        repeat (70) push_cmd(ACT_SLOWER, MS_FULL);
        push_cmd(ACT_FASTER, MS_FULL);
        push_cmd(ACT_TICK, MS_FULL);
        wait_idle();
        write_reg(CFG_SPEED_INCREMENT, 10'd1023);
        @(posedge i_clk);
        repeat (66) push_cmd(ACT_FASTER, MS_FULL);
        push_cmd(ACT_RUN_LEFT, MS_FULL);
        wait_idle();

        // Random phases, each under its own register setting: all motors
        // including none, zero / unit / largest increments.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_MOTOR_SELECT, motor_word(2'd2));
                    write_reg(CFG_SPEED_INCREMENT, 10'd1000);
                end
                1: begin
                    write_reg(CFG_MOTOR_SELECT, motor_word(2'd3));
                    write_reg(CFG_SPEED_INCREMENT, 10'd1);
                end
                2: begin
                    write_reg(CFG_MOTOR_SELECT, motor_word(2'd0));
                    write_reg(CFG_SPEED_INCREMENT, 10'd0);
                end
                3: begin
                    write_reg(CFG_MOTOR_SELECT, motor_word(2'd1));
                    write_reg(CFG_SPEED_INCREMENT, 10'd1023);
                end
                4: begin
                    write_reg(CFG_MOTOR_SELECT, motor_word(2'd3));
                    write_reg(CFG_SPEED_INCREMENT, CFG_D_W'($urandom_range(1, 64)));
                end
                default: begin
                    write_reg(CFG_MOTOR_SELECT, motor_word(MOTOR_W'($urandom_range(1, 3))));
                    write_reg(CFG_SPEED_INCREMENT, CFG_D_W'($urandom_range(0, 1023)));
                end
            endcase
            @(posedge i_clk);
            counted = 0;
            while (counted < PHASE_ITEMS) push_random_cmd(counted);
            wait_idle();
        end

        if (errors == 0) begin
            $display("PASS stepper_command_shift_out");
        end else begin
            $display("FAIL stepper_command_shift_out");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/scso_pkg.sv
hdl/scso_cell.sv
hdl/scso_ctrl.sv
hdl/stepper_command_shift_out.sv
verif/tb.sv
